// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the block's modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// cond must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// cons must hold at the edge after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/lis_pkg.sv =====
// ----------------------------------------------------------------------------
// lis_pkg
// Sizes and the token that walks the tail cell chain.
// ----------------------------------------------------------------------------
package lis_pkg;

   localparam int MAX_LEN = 1024;
   localparam int DATA_W  = 32;
   localparam int LEN_W   = 11;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   typedef struct packed {
      logic                     vld;
      logic                     last;
      logic                     placed;
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0]         count;
   } token_type;

endpackage

// ===== src/lis_if.sv =====
// ----------------------------------------------------------------------------
// lis_req_if / lis_rsp_if
// Valid/ready channels for input values and length results.
// ----------------------------------------------------------------------------
interface lis_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [lis_pkg::DATA_W-1:0] value;
   logic                              last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface lis_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lis_pkg::LEN_W-1:0] lis_length;
   logic                      is_final;
   logic                      overflow;

   modport source (output valid, output lis_length, output is_final, output overflow,
                   input ready);
   modport sink (input valid, input lis_length, input is_final, input overflow,
                 output ready);
endinterface

// ===== src/lis_cell.sv =====
// ----------------------------------------------------------------------------
// lis_cell
// One tail slot: takes the first passing value not above its tail, counts
// its own occupancy into the token and hands the token on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lis_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  lis_pkg::token_type tok_in,
   output lis_pkg::token_type tok_out
);

   logic                              occ_ff;
   logic                              occ_in;
   logic signed [lis_pkg::DATA_W-1:0] tail_ff;
   logic signed [lis_pkg::DATA_W-1:0] tail_in;
   lis_pkg::token_type                tok_ff;
   lis_pkg::token_type                tok_in_nxt;
   logic                              hit;
   logic                              occ_after;

   assign hit = tok_in.vld && !tok_in.placed &&
                (!occ_ff || ($signed(tail_ff) >= $signed(tok_in.value)));
   assign occ_after = occ_ff || hit;

   always_comb begin
      occ_in  = occ_ff;
      tail_in = tail_ff;
      if (adv && tok_in.vld) begin
         if (hit) begin
            tail_in = tok_in.value;
         end
         // drop the slot once the closing beat has passed
         occ_in = occ_after && !tok_in.last;
      end
   end

   always_comb begin
      tok_in_nxt        = tok_in;
      tok_in_nxt.placed = tok_in.placed || hit;
      tok_in_nxt.count  = tok_in.count + lis_pkg::CNT_W'(occ_after);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         occ_ff <= occ_in;
         if (adv) begin
            tok_ff <= tok_in_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
   end

   assign tok_out = tok_ff;

   `ASSERT_ALWAYS(a_placed_counts, clock, reset, !(tok_ff.vld && tok_ff.placed) || (tok_ff.count != '0), "placed token with zero length")
   `ASSERT_NEXT(a_last_clears, clock, reset, adv && tok_in.vld && tok_in.last, !occ_ff, "slot kept after closing beat")

endmodule

// ===== src/lis_out.sv =====
// ----------------------------------------------------------------------------
// lis_out
// Result register at the end of the chain: sticky overflow per sequence and
// the chain-wide advance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lis_out (
   input  logic               clock,
   input  logic               reset,
   input  lis_pkg::token_type tok,
   output logic               adv,
   lis_rsp_if.source          rsp
);

   logic                      vld_ff;
   logic                      vld_in;
   logic                      ovf_ff;
   logic                      ovf_in;
   logic                      ovf_now;
   logic [lis_pkg::LEN_W-1:0] len_ff;
   logic                      fin_ff;
   logic                      rsp_ovf_ff;

   assign adv     = !vld_ff || rsp.ready;
   assign ovf_now = ovf_ff || !tok.placed;

   always_comb begin
      vld_in = vld_ff;
      ovf_in = ovf_ff;
      if (adv) begin
         vld_in = tok.vld;
         if (tok.vld) begin
            ovf_in = ovf_now && !tok.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tok.vld) begin
         len_ff     <= lis_pkg::LEN_W'(tok.count);
         fin_ff     <= tok.last;
         rsp_ovf_ff <= ovf_now;
      end
   end

   assign rsp.valid      = vld_ff;
   assign rsp.lis_length = len_ff;
   assign rsp.is_final   = fin_ff;
   assign rsp.overflow   = rsp_ovf_ff;

   `ASSERT_ALWAYS(a_ovf_full, clock, reset, !(vld_ff && rsp_ovf_ff) || (len_ff == lis_pkg::LEN_W'(lis_pkg::MAX_LEN)), "overflow reported below capacity")
   `ASSERT_NEXT(a_ovf_clear, clock, reset, adv && tok.vld && tok.last, !ovf_ff, "overflow kept across sequences")

endmodule

// ===== src/longest_increasing_subsequence_length.sv =====
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_length
// Streaming length of the longest strictly increasing subsequence.
// ----------------------------------------------------------------------------
// Values arrive as beats on req_chan (value, last); every beat yields one
// beat on rsp_chan carrying the running length, is_final (a copy of last)
// and overflow (an append was lost to a full table earlier in the sequence
// or on this beat). A beat marked last closes the sequence; the block is
// clean for the next value right behind it.
// The tails live in a row of MAX_LEN cells. A beat walks the row one cell a
// cycle (the row holds while the receiver stalls), lands in the first empty
// cell or the first cell whose tail is not below it, and counts occupied
// cells on its way to the result register. Throughput: one beat per cycle,
// back to back, including across sequences, unless the receiver stalls. An
// accepted beat passes each cell in turn and then the result register.
// Reset empties all cells and the result register; no beat is in flight.
// When the receiver stalls, the whole row holds and req_chan.ready drops
// until the waiting result is taken.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_length (
   input  logic    clock,
   input  logic    reset,
   lis_req_if.sink req_chan,
   lis_rsp_if.source rsp_chan
);

   lis_pkg::token_type tok [lis_pkg::MAX_LEN+1];
   lis_pkg::token_type tok_head;
   logic               adv;

   assign req_chan.ready = adv;

   always_comb begin
      tok_head        = '0;
      tok_head.vld    = req_chan.valid;
      tok_head.last   = req_chan.last;
      tok_head.value  = req_chan.value;
   end

   assign tok[0] = tok_head;

   for (genvar k = 0; k < lis_pkg::MAX_LEN; k++) begin : g_cell
      lis_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .tok_in  (tok[k]),
         .tok_out (tok[k+1])
      );
   end

   lis_out u_out (
      .clock (clock),
      .reset (reset),
      .tok   (tok[lis_pkg::MAX_LEN]),
      .adv   (adv),
      .rsp   (rsp_chan)
   );

endmodule
